[src/length_prefixed_record_ring_top_assert.svh]
`ifndef LENGTH_PREFIXED_RECORD_RING_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_RING_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define LPRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define LPRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lprr_pkg.sv]
package lprr_pkg;

  // field widths
  localparam int REQ_W    = 2;
  localparam int LEN_W    = 12;
  localparam int TS_W     = 63;
  localparam int DB_W     = 8;
  localparam int STATUS_W = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 11;
  localparam int FREE_W   = 13;
  localparam int CFG_W    = 13;

  // beat layouts
  localparam int LEN_LSB      = 0;
  localparam int TS_LSB       = LEN_LSB + LEN_W;
  localparam int DB_LSB       = TS_LSB + TS_W;
  localparam int IN_TDATA_W   = 88;
  localparam int OUT_FIELDS_W = BYTE_W + COUNT_W + TS_W + FREE_W;
  localparam int OUT_TDATA_W  = 96;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int OUT_TUSER_W  = STATUS_W + 1;

  // store sizing
  localparam int MAX_BYTES_DEFAULT = 4096;
  localparam int CAP_RESET         = 4096;
  localparam int CAP_MIN           = 16;
  localparam int PREFIX_BYTES      = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NO_OPEN   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PFX_HI,
    S_RD_HI,
    S_RD_LEN,
    S_RD_ADDR,
    S_RD_BYTE,
    S_DONE
  } state_t;

  typedef enum logic {
    RD_AT_POS,
    RD_AT_POS1
  } rd_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    take;
    logic    clear;
    logic    pfx_lo;
    logic    pfx_hi;
    logic    wr_byte;
    logic    len_lo;
    logic    rd_open;
    logic    rd_byte;
    logic    set_status;
    status_t status;
    rd_sel_t rd_sel;
    logic    load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic too_large;
    logic no_room;
    logic write_open;
    logic read_open;
    logic have_rec;
    logic len_zero;
  } stat_t;

endpackage

[src/length_prefixed_record_ring_top.sv]
// Channel  Dir  Fields (lowest bit first)
// cfg      in   cfg_data: capacity_bytes[12:0]
// s_*      in   tuser: req_type[1:0]; tdata: record_length[11:0], record_timestamp[74:12],
//               data_byte[82:75]
// m_*      out  tuser: status[2:0], byte_valid[3]; tlast: record_end;
//               tdata: read_byte[7:0], record_count[18:8], oldest_timestamp[81:19],
//               free_bytes[94:82]
//
// States after IDLE, ending in DONE: byte, clear or rejected item EXEC; start EXEC, PFX_HI;
// read inside an open record EXEC, RD_BYTE; read opening a record EXEC, RD_HI, RD_LEN, and for
// nonzero length RD_ADDR, RD_BYTE (prefix read via the store's single registered port).
// A finished result waits until the output register is free; the next item is taken while
// the previous result still waits on m_tready. A cfg beat also empties the ring.
// rst is synchronous: restores capacity 4096 (clamped to MAX_BYTES), empties the ring.
module length_prefixed_record_ring_top #(
  parameter int MAX_BYTES = lprr_pkg::MAX_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lprr_pkg::CFG_W-1:0]       cfg_data,  // capacity_bytes
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lprr_pkg::IN_TDATA_W-1:0]  s_tdata,   // record_length, record_timestamp,
                                                      // data_byte
  input  logic [lprr_pkg::REQ_W-1:0]       s_tuser,   // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lprr_pkg::OUT_TDATA_W-1:0] m_tdata,   // read_byte, record_count,
                                                      // oldest_timestamp, free_bytes
  output logic [lprr_pkg::OUT_TUSER_W-1:0] m_tuser,   // status, byte_valid
  output logic                             m_tlast    // record_end
);

  lprr_pkg::cmd_t  cmd;
  lprr_pkg::stat_t stat;

  // register writes are taken in any cycle out of reset
  assign cfg_ready = !rst;

  lprr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lprr_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[src/lprr_ctrl.sv]
`include "length_prefixed_record_ring_top_assert.svh"

module lprr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  lprr_pkg::stat_t  stat,
  output lprr_pkg::cmd_t   cmd
);

  lprr_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lprr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lprr_pkg::S_IDLE: begin
        if (s_tvalid) state_next = lprr_pkg::S_EXEC;
      end
      lprr_pkg::S_EXEC: begin
        case (stat.req)
          lprr_pkg::REQ_START: begin
            if (stat.too_large || stat.no_room) state_next = lprr_pkg::S_DONE;
            else state_next = lprr_pkg::S_PFX_HI;
          end
          lprr_pkg::REQ_READ: begin
            if (stat.read_open) state_next = lprr_pkg::S_RD_BYTE;
            else if (stat.have_rec) state_next = lprr_pkg::S_RD_HI;
            else state_next = lprr_pkg::S_DONE;
          end
          default: state_next = lprr_pkg::S_DONE;
        endcase
      end
      lprr_pkg::S_PFX_HI:  state_next = lprr_pkg::S_DONE;
      lprr_pkg::S_RD_HI:   state_next = lprr_pkg::S_RD_LEN;
      lprr_pkg::S_RD_LEN: begin
        if (stat.len_zero) state_next = lprr_pkg::S_DONE;
        else state_next = lprr_pkg::S_RD_ADDR;
      end
      lprr_pkg::S_RD_ADDR: state_next = lprr_pkg::S_RD_BYTE;
      lprr_pkg::S_RD_BYTE: state_next = lprr_pkg::S_DONE;
      lprr_pkg::S_DONE: begin
        if (out_free) state_next = lprr_pkg::S_IDLE;
      end
      default: state_next = lprr_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.status = lprr_pkg::ST_OK;
    cmd.rd_sel = lprr_pkg::RD_AT_POS;
    s_tready = 1'b0;
    case (state)
      lprr_pkg::S_IDLE: begin
        // no beat is taken while reset is held
        s_tready = !rst;
        cmd.take = s_tvalid && !rst;
      end
      lprr_pkg::S_EXEC: begin
        case (stat.req)
          lprr_pkg::REQ_START: begin
            if (stat.too_large) begin
              cmd.set_status = 1'b1;
              cmd.status = lprr_pkg::ST_TOO_LARGE;
            end else if (stat.no_room) begin
              cmd.set_status = 1'b1;
              cmd.status = lprr_pkg::ST_FULL;
            end else begin
              cmd.pfx_lo = 1'b1;
            end
          end
          lprr_pkg::REQ_BYTE: begin
            if (stat.write_open) begin
              cmd.wr_byte = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status = lprr_pkg::ST_NO_OPEN;
            end
          end
          lprr_pkg::REQ_READ: begin
            if (!stat.read_open && !stat.have_rec) begin
              cmd.set_status = 1'b1;
              cmd.status = lprr_pkg::ST_EMPTY;
            end
          end
          lprr_pkg::REQ_CLEAR: cmd.clear = 1'b1;
          default: cmd.clear = 1'b0;
        endcase
      end
      lprr_pkg::S_PFX_HI: cmd.pfx_hi = 1'b1;
      lprr_pkg::S_RD_HI: begin
        cmd.rd_sel = lprr_pkg::RD_AT_POS1;
        cmd.len_lo = 1'b1;
      end
      lprr_pkg::S_RD_LEN:  cmd.rd_open = 1'b1;
      lprr_pkg::S_RD_BYTE: cmd.rd_byte = 1'b1;
      lprr_pkg::S_DONE:    cmd.load_out = out_free;
      default: cmd.take = 1'b0;
    endcase
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `LPRR_ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "result overwritten")
  `LPRR_ASSERT_NEXT(a_load_shows, cmd.load_out, m_tvalid, "loaded result not presented")

endmodule

[src/lprr_dp.sv]
`include "length_prefixed_record_ring_top_assert.svh"

module lprr_dp #(
  parameter int MAX_BYTES = lprr_pkg::MAX_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [lprr_pkg::CFG_W-1:0]         cfg_data,
  input  logic [lprr_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [lprr_pkg::REQ_W-1:0]         s_tuser,
  output logic [lprr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [lprr_pkg::OUT_TUSER_W-1:0]   m_tuser,
  output logic                               m_tlast,
  input  lprr_pkg::cmd_t                     cmd,
  output lprr_pkg::stat_t                    stat
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int RW = $clog2(MAX_BYTES / 4 + 1);
  localparam int VW = (CW > lprr_pkg::CFG_W) ? CW : lprr_pkg::CFG_W;
  localparam int EW = lprr_pkg::LEN_W + 1;
  localparam int CAP_RST = (lprr_pkg::CAP_RESET > MAX_BYTES) ? MAX_BYTES
                                                             : lprr_pkg::CAP_RESET;

  // byte store
  logic [7:0] mem [MAX_BYTES];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  // ring state
  logic [CW-1:0] cap;
  logic [AW-1:0] write_pos, read_pos;
  logic [RW-1:0] stored_records;
  logic [lprr_pkg::TS_W-1:0] least_ts, pending_ts;
  logic [lprr_pkg::LEN_W-1:0] write_remaining, read_remaining;
  logic write_open, read_open;
  logic [CW-1:0] used_bytes;

  // latched item and result
  lprr_pkg::req_t in_req;
  logic [lprr_pkg::LEN_W-1:0] in_len;
  logic [lprr_pkg::TS_W-1:0] in_ts;
  logic [lprr_pkg::DB_W-1:0] in_db;
  lprr_pkg::status_t res_status;
  logic [7:0] res_byte;
  logic res_valid, res_end;
  logic [7:0] len_lo;

  // derived values
  logic [CW-1:0] free_bytes;
  logic [EW-1:0] entry;
  logic [lprr_pkg::LEN_W-1:0] rd_len;
  logic [VW-1:0] cfg_ext;
  logic [CW-1:0] cap_cfg;
  logic complete;
  logic [lprr_pkg::TS_W-1:0] comp_ts;
  logic [AW-1:0] wp1, wp4, rp1, rp4;
  logic do_clear;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p, input logic [2:0] n,
                                         input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW + 1)'(p) + (CW + 1)'(n);
    if (s >= {1'b0, c}) s = s - {1'b0, c};
    return AW'(s);
  endfunction

  assign free_bytes = cap - used_bytes;
  assign entry = EW'(in_len) + EW'(lprr_pkg::PREFIX_BYTES);
  assign rd_len = {rd_data[3:0], len_lo};
  assign wp1 = wrap(write_pos, 3'd1, cap);
  assign wp4 = wrap(write_pos, 3'(lprr_pkg::PREFIX_BYTES), cap);
  assign rp1 = wrap(read_pos, 3'd1, cap);
  assign rp4 = wrap(read_pos, 3'(lprr_pkg::PREFIX_BYTES), cap);
  assign do_clear = cfg_valid || cmd.clear;

  // capacity clamp for register writes
  always_comb begin
    cfg_ext = VW'(cfg_data);
    if (cfg_ext > VW'(MAX_BYTES)) cap_cfg = CW'(MAX_BYTES);
    else if (cfg_ext < VW'(lprr_pkg::CAP_MIN)) cap_cfg = CW'(lprr_pkg::CAP_MIN);
    else cap_cfg = CW'(cfg_ext);
  end

  // status to controller
  always_comb begin
    stat.req        = in_req;
    stat.too_large  = VW'(entry) > VW'(cap >> 2);
    stat.no_room    = write_open || (VW'(entry) > VW'(free_bytes));
    stat.write_open = write_open;
    stat.read_open  = read_open;
    stat.have_rec   = stored_records != '0;
    stat.len_zero   = rd_len == '0;
  end

  // record completion: on a zero-length start or the last payload byte
  always_comb begin
    complete = (cmd.pfx_hi && in_len == '0) ||
               (cmd.wr_byte && write_remaining == lprr_pkg::LEN_W'(1));
    comp_ts = cmd.pfx_hi ? in_ts : pending_ts;
  end

  // memory ports
  always_comb begin
    rd_addr = (cmd.rd_sel == lprr_pkg::RD_AT_POS1) ? rp1 : read_pos;
    wr_en = cmd.pfx_lo || cmd.pfx_hi || cmd.wr_byte;
    wr_addr = cmd.pfx_hi ? wp1 : write_pos;
    if (cmd.pfx_lo) wr_data = in_len[7:0];
    else if (cmd.pfx_hi) wr_data = 8'(in_len[lprr_pkg::LEN_W-1:8]);
    else wr_data = in_db;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // item latch and result fields
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_req     <= lprr_pkg::req_t'(s_tuser);
      in_len     <= s_tdata[lprr_pkg::LEN_LSB +: lprr_pkg::LEN_W];
      in_ts      <= s_tdata[lprr_pkg::TS_LSB +: lprr_pkg::TS_W];
      in_db      <= s_tdata[lprr_pkg::DB_LSB +: lprr_pkg::DB_W];
      res_status <= lprr_pkg::ST_OK;
      res_byte   <= '0;
      res_valid  <= 1'b0;
      res_end    <= 1'b0;
    end else begin
      if (cmd.set_status) res_status <= cmd.status;
      if (cmd.rd_byte) begin
        res_byte  <= rd_data;
        res_valid <= 1'b1;
        if (read_remaining == lprr_pkg::LEN_W'(1)) res_end <= 1'b1;
      end
      if (cmd.rd_open && rd_len == '0) res_end <= 1'b1;
    end
    if (cmd.len_lo) len_lo <= rd_data;
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap             <= CW'(CAP_RST);
      write_pos       <= '0;
      read_pos        <= '0;
      stored_records  <= '0;
      least_ts        <= '0;
      pending_ts      <= '0;
      write_remaining <= '0;
      read_remaining  <= '0;
      write_open      <= 1'b0;
      read_open       <= 1'b0;
      used_bytes      <= '0;
    end else if (do_clear) begin
      if (cfg_valid) cap <= cap_cfg;
      write_pos       <= '0;
      read_pos        <= '0;
      stored_records  <= '0;
      least_ts        <= '0;
      pending_ts      <= '0;
      write_remaining <= '0;
      read_remaining  <= '0;
      write_open      <= 1'b0;
      read_open       <= 1'b0;
      used_bytes      <= '0;
    end else begin
      // write side
      if (cmd.pfx_hi) begin
        write_pos       <= wp4;
        used_bytes      <= used_bytes + CW'(entry);
        pending_ts      <= in_ts;
        write_remaining <= in_len;
        write_open      <= in_len != '0;
      end
      if (cmd.wr_byte) begin
        write_pos       <= wp1;
        write_remaining <= write_remaining - 1'b1;
        if (write_remaining == lprr_pkg::LEN_W'(1)) write_open <= 1'b0;
      end
      if (complete) begin
        stored_records <= stored_records + 1'b1;
        if (least_ts == '0 || comp_ts < least_ts) least_ts <= comp_ts;
      end
      // read side: prefix
      if (cmd.rd_open) begin
        read_pos <= rp4;
        used_bytes <= (used_bytes >= CW'(lprr_pkg::PREFIX_BYTES))
                      ? used_bytes - CW'(lprr_pkg::PREFIX_BYTES) : '0;
        read_remaining <= rd_len;
        if (rd_len == '0) begin
          read_open <= 1'b0;
          if (stored_records != '0) stored_records <= stored_records - 1'b1;
        end else begin
          read_open <= 1'b1;
        end
      end
      // read side: payload byte
      if (cmd.rd_byte) begin
        read_pos <= rp1;
        if (used_bytes != '0) used_bytes <= used_bytes - 1'b1;
        read_remaining <= read_remaining - 1'b1;
        if (read_remaining == lprr_pkg::LEN_W'(1)) begin
          read_open <= 1'b0;
          if (stored_records != '0) stored_records <= stored_records - 1'b1;
        end
      end
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {{lprr_pkg::OUT_PAD_W{1'b0}}, lprr_pkg::FREE_W'(free_bytes), least_ts,
                  lprr_pkg::COUNT_W'(stored_records), res_byte};
      m_tuser <= {res_valid, res_status};
      m_tlast <= res_end;
    end
  end

  `LPRR_ASSERT_NOW(a_used_in_cap, 1'b1, used_bytes <= cap, "used bytes exceed capacity")
  `LPRR_ASSERT_NOW(a_pos_in_cap, 1'b1, (CW'(write_pos) < cap) && (CW'(read_pos) < cap), "position beyond capacity")
  `LPRR_ASSERT_NOW(a_read_has_rec, read_open, stored_records != '0, "open read without a stored record")

endmodule

[bench/tb_length_prefixed_record_ring_top.sv]
module tb_length_prefixed_record_ring_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT       = 300000;
  localparam int BEATS_PER_PHASE = 183;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int IDLE_PCT        = 38;
  localparam int NUM_PHASES      = 9;
  // widths and sizes from the package
  localparam int LEN_W        = lprr_pkg::LEN_W;
  localparam int TS_W         = lprr_pkg::TS_W;
  localparam int DB_W         = lprr_pkg::DB_W;
  localparam int BYTE_W       = lprr_pkg::BYTE_W;
  localparam int COUNT_W      = lprr_pkg::COUNT_W;
  localparam int FREE_W       = lprr_pkg::FREE_W;
  localparam int STATUS_W     = lprr_pkg::STATUS_W;
  localparam int CFG_W        = lprr_pkg::CFG_W;
  localparam int REQ_W        = lprr_pkg::REQ_W;
  localparam int IN_TDATA_W   = lprr_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = lprr_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W  = lprr_pkg::OUT_TUSER_W;
  localparam int PREFIX_BYTES = lprr_pkg::PREFIX_BYTES;
  localparam int MAX_BYTES    = lprr_pkg::MAX_BYTES_DEFAULT;
  localparam int CAP_MIN      = lprr_pkg::CAP_MIN;
  localparam int CAP_RESET    = lprr_pkg::CAP_RESET;
  localparam int IN_FIELDS_W  = LEN_W + TS_W + DB_W;
  // result tdata layout
  localparam int CNT_LSB  = BYTE_W;
  localparam int OLD_LSB  = CNT_LSB + COUNT_W;
  localparam int FREE_LSB = OLD_LSB + TS_W;
  localparam logic [TS_W-1:0] TS_MAX = '1;

  typedef struct packed {
    lprr_pkg::status_t   st;
    logic [BYTE_W-1:0]   rbyte;
    logic                bvalid;
    logic                rend;
    logic [COUNT_W-1:0]  count;
    logic [TS_W-1:0]     oldest;
    logic [FREE_W-1:0]   free;
  } ring_reply_t;

  typedef struct packed {
    lprr_pkg::req_t    req;
    logic [LEN_W-1:0]  len;
    logic [TS_W-1:0]   ts;
    logic [DB_W-1:0]   db;
    logic              typed;
    ring_reply_t       reply;
  } stim_row_t;

  // directed rows; typed replies only where the answer is obvious
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    // read and stray byte on an empty ring
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b1,
      '{lprr_pkg::ST_EMPTY, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}},
    '{lprr_pkg::REQ_BYTE,  12'hFFF,  TS_MAX,  8'hFF, 1'b1,
      '{lprr_pkg::ST_NO_OPEN, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}},
    // oversize starts
    '{lprr_pkg::REQ_START, 12'hFFF,  TS_MAX,  8'h00, 1'b1,
      '{lprr_pkg::ST_TOO_LARGE, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}},
    '{lprr_pkg::REQ_START, 12'd1021, 63'd1,   8'h00, 1'b1,
      '{lprr_pkg::ST_TOO_LARGE, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}},
    // empty record with timestamp zero, then a record that replaces the zero
    '{lprr_pkg::REQ_START, 12'd0,    63'd0,   8'h00, 1'b1,
      '{lprr_pkg::ST_OK, 8'd0, 1'b0, 1'b0, 11'd1, 63'd0, 13'd4092}},
    '{lprr_pkg::REQ_START, 12'd2,    TS_MAX,  8'h00, 1'b1,
      '{lprr_pkg::ST_OK, 8'd0, 1'b0, 1'b0, 11'd1, 63'd0, 13'd4086}},
    '{lprr_pkg::REQ_START, 12'd1,    63'd3,   8'h00, 1'b1,
      '{lprr_pkg::ST_FULL, 8'd0, 1'b0, 1'b0, 11'd1, 63'd0, 13'd4086}},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'hFF, 1'b0, '0},
    // zero-length read, two bytes, then empty
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b0, '0},
    // largest record that fits, abandoned by clear
    '{lprr_pkg::REQ_START, 12'd1020, 63'd5,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'hA5, 1'b0, '0},
    '{lprr_pkg::REQ_CLEAR, 12'd0,    63'd0,   8'h00, 1'b1,
      '{lprr_pkg::ST_OK, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}},
    // two records, a partial read, clear mid-read
    '{lprr_pkg::REQ_START, 12'd3,    63'd1000, 8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'h01, 1'b0, '0},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'h80, 1'b0, '0},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'h7F, 1'b0, '0},
    '{lprr_pkg::REQ_START, 12'd1,    63'd7,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_BYTE,  12'd0,    63'd0,   8'h55, 1'b0, '0},
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b0, '0},
    '{lprr_pkg::REQ_CLEAR, 12'd0,    63'd0,   8'h00, 1'b1,
      '{lprr_pkg::ST_OK, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}},
    '{lprr_pkg::REQ_READ,  12'd0,    63'd0,   8'h00, 1'b1,
      '{lprr_pkg::ST_EMPTY, 8'd0, 1'b0, 1'b0, 11'd0, 63'd0, 13'd4096}}
  };

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata;    // record_length, record_timestamp, data_byte
  logic [REQ_W-1:0]        s_tuser;    // req_type
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;    // read_byte, record_count, oldest_timestamp, free_bytes
  logic [OUT_TUSER_W-1:0]  m_tuser;    // status, byte_valid
  logic                    m_tlast;    // record_end

  length_prefixed_record_ring_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // ring shadow state
  logic [7:0]     shadow_bytes [0:MAX_BYTES-1];
  int unsigned    cap_used;
  int unsigned    wr_pos, rd_pos, rec_count, wr_left, rd_left, used_bytes;
  logic [TS_W-1:0] least_seen_ts, open_ts;
  bit             wr_active, rd_active;

  ring_reply_t    ring_replies_due [$];
  int             stall_pct = IDLE_PCT;
  int             mismatches = 0;
  int             beats_sent = 0;
  int             results_seen = 0;
  int             bytes_read = 0;
  int             rejected_starts = 0;
  int             empty_reads = 0;
  int             cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_ring();
    wr_pos = 0;
    rd_pos = 0;
    rec_count = 0;
    least_seen_ts = '0;
    wr_left = 0;
    wr_active = 1'b0;
    open_ts = '0;
    rd_left = 0;
    rd_active = 1'b0;
    used_bytes = 0;
  endfunction

  function automatic void close_record();
    rec_count++;
    if (least_seen_ts == '0 || open_ts < least_seen_ts) least_seen_ts = open_ts;
    wr_active = 1'b0;
  endfunction

  // next reply of the ring for one request beat; updates the shadow state
  function automatic ring_reply_t predict_ring_reply(lprr_pkg::req_t rq, logic [LEN_W-1:0] len,
                                                     logic [TS_W-1:0] ts, logic [DB_W-1:0] db);
    ring_reply_t r;
    int unsigned entry, hdr;
    r = '0;
    r.st = lprr_pkg::ST_OK;
    case (rq)
      lprr_pkg::REQ_START: begin
        entry = len + PREFIX_BYTES;
        if (entry > cap_used / 4) begin
          r.st = lprr_pkg::ST_TOO_LARGE;
          rejected_starts++;
        end else if (wr_active || entry > cap_used - used_bytes) begin
          r.st = lprr_pkg::ST_FULL;
          rejected_starts++;
        end else begin
          // little-endian length prefix
          for (int i = 0; i < PREFIX_BYTES; i++)
            shadow_bytes[(wr_pos + i) % cap_used] = 8'(len >> (8 * i));
          wr_pos = (wr_pos + PREFIX_BYTES) % cap_used;
          used_bytes += entry;
          open_ts = ts;
          wr_left = len;
          wr_active = 1'b1;
          if (len == 0) close_record();
        end
      end
      lprr_pkg::REQ_BYTE: begin
        if (!wr_active) begin
          r.st = lprr_pkg::ST_NO_OPEN;
        end else begin
          shadow_bytes[wr_pos] = db;
          wr_pos = (wr_pos + 1) % cap_used;
          wr_left--;
          if (wr_left == 0) close_record();
        end
      end
      lprr_pkg::REQ_READ: begin
        if (!rd_active && rec_count == 0) begin
          r.st = lprr_pkg::ST_EMPTY;
          empty_reads++;
        end else begin
          // fetch the prefix when a new record is opened
          if (!rd_active) begin
            hdr = 0;
            for (int i = 0; i < PREFIX_BYTES; i++)
              hdr |= 32'(shadow_bytes[(rd_pos + i) % cap_used]) << (8 * i);
            rd_pos = (rd_pos + PREFIX_BYTES) % cap_used;
            used_bytes = (used_bytes >= PREFIX_BYTES) ? used_bytes - PREFIX_BYTES : 0;
            rd_left = hdr & 32'hFFF;
            rd_active = 1'b1;
          end
          if (rd_left > 0) begin
            r.rbyte = shadow_bytes[rd_pos];
            r.bvalid = 1'b1;
            rd_pos = (rd_pos + 1) % cap_used;
            if (used_bytes > 0) used_bytes--;
            rd_left--;
            bytes_read++;
          end
          if (rd_left == 0) begin
            r.rend = 1'b1;
            rd_active = 1'b0;
            if (rec_count > 0) rec_count--;
          end
        end
      end
      default: clear_ring();
    endcase
    r.count = COUNT_W'(rec_count);
    r.oldest = least_seen_ts;
    r.free = FREE_W'(cap_used - used_bytes);
    return r;
  endfunction

  // drive one request beat and queue its reply once taken
  task automatic send_beat(lprr_pkg::req_t rq, logic [LEN_W-1:0] len, logic [TS_W-1:0] ts,
                           logic [DB_W-1:0] db, logic typed, ring_reply_t typed_reply);
    ring_reply_t want;
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= rq;
    s_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, db, ts, len};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_ring_reply(rq, len, ts, db);
    if (typed) want = typed_reply;
    ring_replies_due.insert(ring_replies_due.size(), want);
    beats_sent++;
  endtask

  // wait for all replies, then let the block settle
  task automatic drain_replies();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (ring_replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ring_replies_due.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time,
               ring_replies_due.size());
      mismatches += ring_replies_due.size();
      ring_replies_due.delete();
    end
  endtask

  // mostly well-formed records with random content, plus noise
  task automatic run_random_phase(int beats, int read_pct);
    int stop, k, pick, lim, max_len;
    lprr_pkg::req_t rq;
    logic [LEN_W-1:0] len;
    logic [TS_W-1:0] ts;
    ring_reply_t none;
    none = '0;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      max_len = cap_used / 4 - PREFIX_BYTES;
      k = $urandom_range(0, 99);
      pick = $urandom_range(0, 19);
      ts = TS_W'({$urandom(), $urandom()});
      if (pick == 0) ts = '0;
      else if (pick == 1) ts = TS_MAX;
      else if (pick < 6) ts = TS_W'($urandom_range(0, 1000));
      // length: mostly short, a few long, rarely the largest
      pick = $urandom_range(0, 99);
      lim = (pick < 70) ? 6 : (pick < 97) ? 40 : max_len;
      if (lim > max_len) lim = max_len;
      len = (pick == 99) ? LEN_W'(max_len) : LEN_W'($urandom_range(0, lim));
      if (wr_active) begin
        if (k < 88) rq = lprr_pkg::REQ_BYTE;
        else if (k < 93) rq = lprr_pkg::REQ_START;
        else if (k < 98) rq = lprr_pkg::REQ_READ;
        else rq = lprr_pkg::REQ_CLEAR;
      end else begin
        if (k < read_pct) rq = lprr_pkg::REQ_READ;
        else if (k < 94) rq = lprr_pkg::REQ_START;
        else if (k < 96) begin
          rq = lprr_pkg::REQ_START;
          len = LEN_W'($urandom_range(max_len + 1, 4095));
        end else if (k < 98) rq = lprr_pkg::REQ_BYTE;
        else rq = lprr_pkg::REQ_CLEAR;
      end
      if (rq != lprr_pkg::REQ_START) len = LEN_W'($urandom());
      send_beat(rq, len, ts, DB_W'($urandom()), 1'b0, none);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin : result_check
    ring_reply_t want;
    ring_reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got.st     = lprr_pkg::status_t'(m_tuser[STATUS_W-1:0]);
      got.bvalid = m_tuser[STATUS_W];
      got.rend   = m_tlast;
      got.rbyte  = m_tdata[BYTE_W-1:0];
      got.count  = m_tdata[CNT_LSB +: COUNT_W];
      got.oldest = m_tdata[OLD_LSB +: TS_W];
      got.free   = m_tdata[FREE_LSB +: FREE_W];
      if (ring_replies_due.size() == 0) begin
        $display("%0t: expected no result beat, got status %0h data %0h", $time,
                 got.st, m_tdata);
        mismatches++;
      end else begin
        want = ring_replies_due.pop_front();
        check_field("status", 64'(want.st), 64'(got.st));
        check_field("read_byte", 64'(want.rbyte), 64'(got.rbyte));
        check_field("byte_valid", 64'(want.bvalid), 64'(got.bvalid));
        check_field("record_end", 64'(want.rend), 64'(got.rend));
        check_field("record_count", 64'(want.count), 64'(got.count));
        check_field("oldest_timestamp", 64'(want.oldest), 64'(got.oldest));
        check_field("free_bytes", 64'(want.free), 64'(got.free));
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("tb_length_prefixed_record_ring_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cap_plan [NUM_PHASES];
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= lprr_pkg::REQ_START;
    // capacity settings: minimum, clamped low, clamped high, odd sizes, random
    cap_plan = '{13'd16, 13'd0, 13'd8191, 13'd37, 13'd4096, 13'd255, 13'd1024, 13'd17,
                 13'd16};
    cap_plan[NUM_PHASES-1] = CFG_W'($urandom_range(CAP_MIN, MAX_BYTES));
    cap_used = CAP_RESET;
    clear_ring();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset capacity
    foreach (DIRECTED_ROWS[i])
      send_beat(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].ts,
                DIRECTED_ROWS[i].db, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].reply);

    // random phases, each under a new capacity written while idle
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_replies();
      cfg_valid <= 1'b1;
      cfg_data <= cap_plan[ph];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      if (cap_plan[ph] > MAX_BYTES) cap_used = MAX_BYTES;
      else if (cap_plan[ph] < CAP_MIN) cap_used = CAP_MIN;
      else cap_used = cap_plan[ph];
      clear_ring();
      // one phase runs with both sides always ready
      stall_pct = (ph == 4) ? 0 : IDLE_PCT;
      run_random_phase(BEATS_PER_PHASE, $urandom_range(25, 70));
    end
    drain_replies();

    $display("Ran %0d request beats over %0d capacity settings, %0d result beats checked.",
             beats_sent, NUM_PHASES + 1, results_seen);
    $display("Saw %0d payload bytes read, %0d rejected starts, %0d reads on an empty ring.",
             bytes_read, rejected_starts, empty_reads);
    if (mismatches == 0) $display("tb_length_prefixed_record_ring_top passed");
    else $display("tb_length_prefixed_record_ring_top failed");
    $finish;
  end

endmodule
